FILE: src/fir_pkg.sv
// ----------------------------------------------------------------------------
// fir_pkg
// Shared constants and types of the direct-form FIR filter core.
// ----------------------------------------------------------------------------
package fir_pkg;

	localparam int MAX_TAPS       = 512;
	localparam int TAP_AW         = $clog2(MAX_TAPS);
	localparam int TAP_CW         = $clog2(MAX_TAPS + 1);
	localparam int DATA_W         = 32;
	localparam int ACC_W          = 64;
	localparam int ACC_SHIFT      = 31;
	localparam int COEF_IDX_W     = 9;
	localparam int NUM_TAPS_W     = 10;
	localparam int NUM_TAPS_RESET = 511;
	localparam int PADDR_W        = 3;
	localparam int PDATA_W        = 32;

	localparam logic [PADDR_W-3:0] REG_NUM_TAPS = '0;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_FILTER = 1'b1
	} fir_op_t;

endpackage

FILE: src/fir_ram.sv
// ----------------------------------------------------------------------------
// fir_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fir_ram #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/fir_filter_fixed_point_core.sv
// ----------------------------------------------------------------------------
// fir_filter_fixed_point_core
// Direct-form FIR filter on signed 32-bit samples. A load item (opcode 0)
// writes one coefficient. A filter item (opcode 1) pushes its sample into
// the 512-entry history and then runs one shared 32x32 multiply-accumulate
// over the taps, one tap per cycle while no unread result is held by
// out_stall, reading the coefficient and history memories in step; no new
// item is taken until the result has been registered on the output.
// Taps beyond the samples seen since reset count as zero, so no clearing
// pass is needed and the block is ready right after reset.
// The result is bits 62..31 of a wrapping 64-bit sum; num_taps above 512
// acts as 512, and coefficients must be loaded before they are used.
// ----------------------------------------------------------------------------
module fir_filter_fixed_point_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              opcode,
	input  logic signed [fir_pkg::DATA_W-1:0] sample_value,
	input  logic [fir_pkg::COEF_IDX_W-1:0]    coef_index,
	input  logic signed [fir_pkg::DATA_W-1:0] coef_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [fir_pkg::DATA_W-1:0] filtered_sample,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [fir_pkg::PADDR_W-1:0]       paddr,
	input  logic [fir_pkg::PDATA_W-1:0]       pwdata,
	output logic [fir_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready
);

	import fir_pkg::*;

	logic [NUM_TAPS_W-1:0]    num_taps_q;
	logic                     busy_q;
	logic                     issue_q;
	logic [TAP_CW-1:0]        k_q;
	logic [TAP_CW-1:0]        last_q;
	logic [TAP_CW-1:0]        taps_q;
	logic [TAP_CW-1:0]        fill_q;
	logic [TAP_AW-1:0]        wp_q;
	logic [TAP_AW-1:0]        rp_q;
	logic                     valid_s1;
	logic                     last_s1;
	logic                     keep_s1;
	logic                     valid_s2;
	logic                     last_s2;
	logic signed [ACC_W-1:0]  prod_s2;
	logic [ACC_W-1:0]         acc_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] result_q;

	logic                     cfg_wr;
	logic                     in_acc;
	logic                     start;
	logic                     coef_we;
	logic [TAP_AW-1:0]        wp_next;
	logic [TAP_AW-1:0]        rp_next;
	logic [TAP_CW-1:0]        eff_taps;
	logic                     hold;
	logic                     issue_go;
	logic signed [DATA_W-1:0] coef_rd;
	logic signed [DATA_W-1:0] hist_rd;
	logic signed [ACC_W-1:0]  mul;
	logic [ACC_W-1:0]         acc_sum;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[PADDR_W-1:2] == REG_NUM_TAPS) ? PDATA_W'(num_taps_q) : '0;

	assign in_stall        = busy_q;
	assign in_acc          = in_valid && !busy_q;
	assign start           = in_acc && (opcode == OP_FILTER);
	assign coef_we         = in_acc && (opcode == OP_LOAD) && (int'(coef_index) < MAX_TAPS);
	assign out_valid       = out_valid_q;
	assign filtered_sample = result_q;

	assign wp_next  = (wp_q == TAP_AW'(MAX_TAPS - 1)) ? '0 : wp_q + 1'b1;
	assign rp_next  = (rp_q == '0) ? TAP_AW'(MAX_TAPS - 1) : rp_q - 1'b1;
	assign eff_taps = (int'(num_taps_q) > MAX_TAPS) ? TAP_CW'(MAX_TAPS)
	                                                : TAP_CW'(num_taps_q);

	assign hold     = valid_s2 && last_s2 && out_valid_q && out_stall;
	assign issue_go = issue_q && !hold;
	assign mul      = coef_rd * hist_rd;
	assign acc_sum  = acc_q + ACC_W'(prod_s2);

	fir_ram #(
		.DEPTH(MAX_TAPS),
		.WIDTH(DATA_W)
	) u_coef_ram (
		.clk  (clk),
		.we   (coef_we),
		.waddr(TAP_AW'(coef_index)),
		.wdata(coef_value),
		.re   (issue_go),
		.raddr(k_q[TAP_AW-1:0]),
		.rdata(coef_rd)
	);

	fir_ram #(
		.DEPTH(MAX_TAPS),
		.WIDTH(DATA_W)
	) u_hist_ram (
		.clk  (clk),
		.we   (start),
		.waddr(wp_next),
		.wdata(sample_value),
		.re   (issue_go),
		.raddr(rp_q),
		.rdata(hist_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_taps_q <= NUM_TAPS_W'(NUM_TAPS_RESET);
		end else if (cfg_wr && (paddr[PADDR_W-1:2] == REG_NUM_TAPS)) begin
			num_taps_q <= pwdata[NUM_TAPS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			issue_q     <= 1'b0;
			k_q         <= '0;
			last_q      <= '0;
			taps_q      <= '0;
			fill_q      <= '0;
			wp_q        <= '0;
			rp_q        <= '0;
			valid_s1    <= 1'b0;
			last_s1     <= 1'b0;
			keep_s1     <= 1'b0;
			valid_s2    <= 1'b0;
			last_s2     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (start) begin
				busy_q  <= 1'b1;
				issue_q <= 1'b1;
				k_q     <= '0;
				taps_q  <= eff_taps;
				last_q  <= (eff_taps == '0) ? '0 : eff_taps - 1'b1;
				wp_q    <= wp_next;
				rp_q    <= wp_next;
				if (int'(fill_q) < MAX_TAPS) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (!hold) begin
				valid_s1 <= issue_q;
				if (issue_q) begin
					last_s1 <= (k_q == last_q);
					keep_s1 <= (k_q < taps_q) && (k_q < fill_q);
					k_q     <= k_q + 1'b1;
					rp_q    <= rp_next;
					if (k_q == last_q) begin
						issue_q <= 1'b0;
					end
				end
				valid_s2 <= valid_s1;
				last_s2  <= last_s1;
				if (valid_s2 && last_s2) begin
					out_valid_q <= 1'b1;
					busy_q      <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
		end else if (!hold) begin
			prod_s2 <= keep_s1 ? mul : '0;
			if (valid_s2) begin
				acc_q <= acc_sum;
				if (last_s2) begin
					result_q <= acc_sum[ACC_SHIFT+DATA_W-1:ACC_SHIFT];
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q && issue_q)
		else $error("filter item did not start a run");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fill_q) <= MAX_TAPS)
		else $error("history fill count out of range");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		issue_q |-> (k_q <= last_q))
		else $error("tap counter ran past the last tap");

	a_hold_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		hold |=> valid_s2 && last_s2 && busy_q)
		else $error("final product lost while output held");

	a_idle_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !issue_q && !valid_s1 && !valid_s2)
		else $error("pipeline active while block idle");
`endif

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fixed-point FIR filter core. Coefficient loads
// and samples are queued in phases, each phase with its own tap count set
// over APB while the core is idle. Every accepted sample runs through a
// bit-true model of the filter, and each result is checked against the
// oldest prediction. Input bursts and output stalls are random.
// ----------------------------------------------------------------------------
module tb_top;

	import fir_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int PHASE_SETTLE = 8;
	localparam int DRAIN_SETTLE = 520;
	localparam logic [PADDR_W-3:0] REG_UNUSED = 1'b1;

	typedef struct {
		fir_op_t                   op;
		logic signed [DATA_W-1:0]  smp;
		logic [COEF_IDX_W-1:0]     idx;
		logic signed [DATA_W-1:0]  coef;
	} fir_item_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_HOLD,
		STALL_COIN,
		STALL_TOGGLE
	} stall_mode_t;

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic                      opcode = 1'b0;
	logic signed [DATA_W-1:0]  sample_value = '0;
	logic [COEF_IDX_W-1:0]     coef_index = '0;
	logic signed [DATA_W-1:0]  coef_value = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic signed [DATA_W-1:0]  filtered_sample;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [PADDR_W-1:0]        paddr = '0;
	logic [PDATA_W-1:0]        pwdata = '0;
	logic [PDATA_W-1:0]        prdata;
	logic                      pready;

	fir_filter_fixed_point_core uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.opcode          (opcode),
		.sample_value    (sample_value),
		.coef_index      (coef_index),
		.coef_value      (coef_value),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.filtered_sample (filtered_sample),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	fir_item_t                 input_items[$];
	fir_item_t                 next_item;
	logic signed [DATA_W-1:0]  filtered_due[$];
	bit                        coef_written [MAX_TAPS];

	logic signed [DATA_W-1:0]  sample_line [MAX_TAPS] = '{default: '0};
	logic signed [DATA_W-1:0]  coef_store [MAX_TAPS] = '{default: '0};
	int unsigned               hist_ptr = 0;
	logic [NUM_TAPS_W-1:0]     taps_cfg = NUM_TAPS_W'(NUM_TAPS_RESET);

	int unsigned               burst_left = 0;
	int unsigned               gap_left = 0;
	int unsigned               stall_run = 0;
	stall_mode_t               stall_mode = STALL_NONE;
	int unsigned               idle_cycles = 0;
	int unsigned               error_count = 0;

	int unsigned phase_taps  [14] = '{1, 3, 2, 8, 17, 0, 33, 512, 1023, 700, 100, 511, 5, 64};
	int unsigned phase_items [14] = '{80, 80, 60, 80, 60, 40, 60, 10, 10, 8, 30, 10, 80, 40};

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic signed [DATA_W-1:0] fir_output_for(
		input logic signed [DATA_W-1:0] x);
		int unsigned      taps;
		int unsigned      pos;
		logic [ACC_W-1:0] acc;
		taps = (taps_cfg > MAX_TAPS) ? MAX_TAPS : taps_cfg;
		hist_ptr = (hist_ptr == MAX_TAPS - 1) ? 0 : hist_ptr + 1;
		sample_line[hist_ptr] = x;
		acc = '0;
		for (int k = 0; k < taps; k++) begin
			pos = (hist_ptr + MAX_TAPS - k) % MAX_TAPS;
			acc = acc + ACC_W'(longint'(coef_store[k]) * longint'(sample_line[pos]));
		end
		return acc[ACC_SHIFT +: DATA_W];
	endfunction

	function automatic logic [DATA_W-1:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			default: return $urandom();
		endcase
	endfunction

	function automatic void push_load(input int unsigned idx, input logic [DATA_W-1:0] value);
		fir_item_t it;
		it.op = OP_LOAD;
		it.smp = $urandom();
		it.idx = idx[COEF_IDX_W-1:0];
		it.coef = value;
		coef_written[idx] = 1'b1;
		input_items.push_back(it);
	endfunction

	function automatic void push_sample(input logic [DATA_W-1:0] value);
		fir_item_t it;
		it.op = OP_FILTER;
		it.smp = value;
		it.idx = COEF_IDX_W'($urandom());
		it.coef = $urandom();
		input_items.push_back(it);
	endfunction

	// driver: bursts of random length, random gaps between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!in_valid || !in_stall) begin
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (input_items.size() != 0) begin
				next_item = input_items.pop_front();
				in_valid <= 1'b1;
				opcode <= next_item.op;
				sample_value <= next_item.smp;
				coef_index <= next_item.idx;
				coef_value <= next_item.coef;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 16);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_run <= 0;
			stall_mode <= STALL_NONE;
		end else if (stall_run == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_run <= $urandom_range(1, 24);
			out_stall <= 1'b0;
		end else begin
			stall_run <= stall_run - 1;
			case (stall_mode)
				STALL_NONE: out_stall <= 1'b0;
				STALL_HOLD: out_stall <= 1'b1;
				STALL_COIN: out_stall <= $urandom_range(0, 1);
				default: out_stall <= ~out_stall;
			endcase
		end
	end

	// monitor: predict on accepted input, check accepted output
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				if (opcode == OP_FILTER) begin
					filtered_due.push_back(fir_output_for(sample_value));
				end else if (coef_index < MAX_TAPS) begin
					coef_store[coef_index] = coef_value;
				end
			end
			if (out_valid && !out_stall) begin
				if (filtered_due.size() == 0) begin
					$display("%0t unexpected filtered_sample %0d", $time, filtered_sample);
					error_count++;
				end else if (filtered_sample !== filtered_due[0]) begin
					$display("%0t filtered_sample expected %0d actual %0d",
						$time, filtered_due[0], filtered_sample);
					error_count++;
					void'(filtered_due.pop_front());
				end else begin
					void'(filtered_due.pop_front());
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		wait (arst_n);
		while (idle_cycles < IDLE_LIMIT) @(posedge clk);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic cfg_write(input logic [PADDR_W-3:0] reg_idx, input logic [PDATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_idx == REG_NUM_TAPS) begin
			taps_cfg = value[NUM_TAPS_W-1:0];
		end
		@(negedge clk);
	endtask

	task automatic verify_num_taps();
		logic [PDATA_W-1:0] got;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {REG_NUM_TAPS, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== PDATA_W'(taps_cfg)) begin
			$display("%0t num_taps readback expected %0d actual %0d", $time, taps_cfg, got);
			error_count++;
		end
		@(negedge clk);
	endtask

	task automatic wait_idle(input int unsigned settle);
		do @(negedge clk); while (input_items.size() != 0 || in_valid || filtered_due.size() != 0);
		repeat (settle) @(negedge clk);
	endtask

	task automatic run_phase(input int unsigned taps, input int unsigned n_items);
		int unsigned        eff;
		int unsigned        hi;
		logic [PDATA_W-1:0] word;
		eff = (taps > MAX_TAPS) ? MAX_TAPS : taps;
		wait_idle(PHASE_SETTLE);
		word = $urandom();
		word[NUM_TAPS_W-1:0] = taps[NUM_TAPS_W-1:0];
		if ($urandom_range(0, 1)) begin
			word[PDATA_W-1:NUM_TAPS_W] = '0;
		end
		cfg_write(REG_NUM_TAPS, word);
		verify_num_taps();
		for (int i = 0; i < eff; i++) begin
			if (!coef_written[i]) begin
				push_load(i, rand_word());
			end
		end
		for (int n = 0; n < n_items; n++) begin
			if ($urandom_range(0, 9) < 3) begin
				hi = (eff != 0 && $urandom_range(0, 1)) ? eff - 1 : MAX_TAPS - 1;
				push_load($urandom_range(0, hi), rand_word());
			end else begin
				push_sample(rand_word());
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		verify_num_taps();
		cfg_write(REG_NUM_TAPS, '0);
		cfg_write(REG_UNUSED, 32'h0000_0155);
		verify_num_taps();

		push_load(0, 32'h7FFF_FFFF);
		push_load(1, 32'h8000_0000);
		push_load(2, 32'hFFFF_FFFF);
		push_load(3, 32'h0000_0001);
		push_load(MAX_TAPS - 1, 32'h8000_0000);
		push_sample(32'h8000_0000);
		push_sample(32'h7FFF_FFFF);

		wait_idle(PHASE_SETTLE);
		cfg_write(REG_NUM_TAPS, 32'd4);
		verify_num_taps();
		push_sample(32'h8000_0000);
		push_sample(32'h8000_0000);
		push_sample(32'h7FFF_FFFF);
		push_sample(32'h0000_0000);
		push_sample(32'hFFFF_FFFF);
		push_sample(32'h8000_0000);
		push_sample(32'h0000_0001);

		for (int p = 0; p < 14; p++) begin
			run_phase(phase_taps[p], phase_items[p]);
		end

		wait_idle(DRAIN_SETTLE);
		if (error_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

FILE: filelist.f
src/fir_pkg.sv
src/fir_ram.sv
src/fir_filter_fixed_point_core.sv
tb/sv/tb_top.sv
